/* design/uuid7_pkg.sv */
`default_nettype none
package uuid7_pkg;

  // Field widths
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned RUPPER_W  = 16;
  localparam int unsigned RLOWER_W  = 64;
  localparam int unsigned CTR_W     = 74;
  localparam int unsigned ID_W      = 128;
  localparam int unsigned NIB_W     = 4;

  // Text layout
  localparam int unsigned CHAR_COUNT = 36;
  localparam int unsigned POS_W      = 6;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHAR_COUNT - 1);
  localparam logic [POS_W-1:0] POS_DASH0 = 6'd8;
  localparam logic [POS_W-1:0] POS_DASH1 = 6'd13;
  localparam logic [POS_W-1:0] POS_DASH2 = 6'd18;
  localparam logic [POS_W-1:0] POS_DASH3 = 6'd23;

  // Version and variant marks
  localparam logic [3:0] VERSION_7  = 4'h7;
  localparam logic [1:0] VARIANT_10 = 2'b10;

  // ASCII
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_OFS = 8'h57;  // 'a' - 10

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef logic [ID_W-1:0] uuid_t;

  typedef struct packed {
    logic  valid;
    uuid_t id;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    uuid_t id;
  } q_head_t;

  // Lower-case hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [NIB_W-1:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A_OFS + ext;
    end
  endfunction

endpackage
`default_nettype wire

/* design/uuid7_if.sv */
`default_nettype none
interface uuid7_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] now_ms;
  logic [15:0] random_upper;
  logic [63:0] random_lower;

  modport source (output valid, output now_ms, output random_upper, output random_lower,
                  input ready);
  modport sink (input valid, input now_ms, input random_upper, input random_lower,
                output ready);
endinterface

interface uuid7_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

/* design/uuid7_front.sv */
`default_nettype none
module uuid7_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  uuid7_in_if.sink            in_req,
  input  wire logic           q_full,
  output uuid7_pkg::q_push_t  q_push
);

  logic [uuid7_pkg::TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [uuid7_pkg::RUPPER_W-1:0] tail_upper_r, tail_upper_nxt;
  logic [uuid7_pkg::RLOWER_W-1:0] tail_lower_r, tail_lower_nxt;
  logic                           seeded_r;

  logic                           newer;
  logic                           accept;
  logic [uuid7_pkg::CTR_W:0]      bumped;
  logic [uuid7_pkg::RUPPER_W-1:0] seed_upper;
  logic [uuid7_pkg::RLOWER_W-1:0] seed_lower;

  assign accept = in_req.valid && !q_full;
  assign in_req.ready = !q_full;

  // Classify the request and build the next identifier
  always_comb begin
    newer  = in_req.now_ms > last_time_r;
    bumped = {1'b0, tail_upper_r[11:0], tail_lower_r[61:0]} + (uuid7_pkg::CTR_W + 1)'(1);
    seed_upper = {uuid7_pkg::VERSION_7, in_req.random_upper[11:0]};
    seed_lower = {uuid7_pkg::VARIANT_10, in_req.random_lower[61:0]};
    priority if (seeded_r && !newer && !bumped[uuid7_pkg::CTR_W]) begin
      // same or earlier time: advance the counter
      last_time_nxt  = last_time_r;
      tail_upper_nxt = {uuid7_pkg::VERSION_7, bumped[73:62]};
      tail_lower_nxt = {uuid7_pkg::VARIANT_10, bumped[61:0]};
    end else if (seeded_r && !newer) begin
      // counter overflow: step the time and reseed
      last_time_nxt  = last_time_r + uuid7_pkg::TIME_W'(1);
      tail_upper_nxt = seed_upper;
      tail_lower_nxt = seed_lower;
    end else begin
      last_time_nxt  = newer ? in_req.now_ms : last_time_r;
      tail_upper_nxt = seed_upper;
      tail_lower_nxt = seed_lower;
    end
  end

  always_comb begin
    q_push.valid = accept;
    q_push.id    = {last_time_nxt, tail_upper_nxt, tail_lower_nxt};
  end

  // Hold the generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      tail_upper_r <= '0;
      tail_lower_r <= '0;
      seeded_r     <= 1'b0;
    end else if (accept) begin
      last_time_r  <= last_time_nxt;
      tail_upper_r <= tail_upper_nxt;
      tail_lower_r <= tail_lower_nxt;
      seeded_r     <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/uuid7_queue.sv */
`default_nettype none
module uuid7_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire uuid7_pkg::q_push_t q_push,
  output logic                q_full,
  output uuid7_pkg::q_head_t  q_head,
  input  wire logic           q_pop
);

  uuid7_pkg::uuid_t                 mem_r [uuid7_pkg::QDEPTH];
  logic [uuid7_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [uuid7_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [uuid7_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             do_pop;

  assign q_full = (count_r == uuid7_pkg::QCNT_W'(uuid7_pkg::QDEPTH));
  assign do_pop = q_pop && (count_r != '0);

  always_comb begin
    q_head.valid = (count_r != '0);
    q_head.id    = mem_r[rd_ptr_r];
  end

  always_comb begin
    count_nxt = count_r;
    if (q_push.valid && !do_pop) begin
      count_nxt = count_r + uuid7_pkg::QCNT_W'(1);
    end else if (!q_push.valid && do_pop) begin
      count_nxt = count_r - uuid7_pkg::QCNT_W'(1);
    end
  end

  // Store identifiers
  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem_r[wr_ptr_r] <= q_push.id;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr_r <= wr_ptr_r + uuid7_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + uuid7_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/uuid7_back.sv */
`default_nettype none
module uuid7_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire uuid7_pkg::q_head_t q_head,
  output logic                q_pop,
  uuid7_out_if.source         out_chr
);

  uuid7_pkg::uuid_t              shift_r;
  logic [uuid7_pkg::POS_W-1:0]   pos_r;
  logic                          busy_r;
  logic                          out_valid_r;
  logic [7:0]                    out_char_r;
  logic                          out_last_r;

  logic                          advance;
  logic                          at_last;
  logic                          is_dash;
  logic [7:0]                    cur_char;

  assign advance = busy_r && (!out_valid_r || out_chr.ready);
  assign at_last = (pos_r == uuid7_pkg::POS_LAST);
  assign q_pop   = q_head.valid && (!busy_r || (advance && at_last));

  // Pick the character at the current position
  always_comb begin
    is_dash = (pos_r == uuid7_pkg::POS_DASH0) || (pos_r == uuid7_pkg::POS_DASH1) ||
              (pos_r == uuid7_pkg::POS_DASH2) || (pos_r == uuid7_pkg::POS_DASH3);
    cur_char = is_dash ? uuid7_pkg::CHAR_DASH
                       : uuid7_pkg::hex_char(shift_r[uuid7_pkg::ID_W-1 -: uuid7_pkg::NIB_W]);
  end

  // Walk the identifier one character per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (advance) begin
      busy_r <= !at_last;
      pos_r  <= pos_r + uuid7_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift_r <= q_head.id;
    end else if (advance && !is_dash) begin
      shift_r <= {shift_r[uuid7_pkg::ID_W-uuid7_pkg::NIB_W-1:0], uuid7_pkg::NIB_W'(0)};
    end
  end

  // Hold the output register until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chr.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= cur_char;
      out_last_r <= at_last;
    end
  end

  assign out_chr.valid     = out_valid_r;
  assign out_chr.text_char = out_char_r;
  assign out_chr.last_char = out_last_r;

endmodule
`default_nettype wire

/* design/monotonic_uuidv7_generator_unit.sv */
// Monotonic UUID version 7 generator.
// in_req carries now_ms, random_upper and random_lower; a request is taken on a
// valid/ready transfer. Each request yields one identifier, sent on out_chr as
// 36 lower-case hex characters with hyphens, one character per transfer, with
// last_char high on the final one.
// The front stage updates the time and counter state and writes the finished
// identifier into a two-entry queue in the cycle of the transfer. The back
// stage reads it out through a nibble shift register into a registered output.
// A request's first character moves from its queue entry through the shift register into the output register.
// Output runs at one character per cycle while the receiver is ready;
// the next identifier follows the last character with no gap.
// Two identifiers can wait in the queue while another is being output.
// Reset clears the time, tail and seeded flag; the first request reseeds.
// When the receiver stalls, the output register holds its character and the
// queue fills; in_req.ready drops once the queue is full.
`default_nettype none
module monotonic_uuidv7_generator_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  uuid7_in_if.sink    in_req,
  uuid7_out_if.source out_chr
);

  uuid7_pkg::q_push_t q_push;
  uuid7_pkg::q_head_t q_head;
  logic               q_full;
  logic               q_pop;

  uuid7_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push)
  );

  uuid7_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  uuid7_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_chr (out_chr)
  );

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [uuid7_pkg::TIME_W-1:0]   now_ms;
    logic [uuid7_pkg::RUPPER_W-1:0] random_upper;
    logic [uuid7_pkg::RLOWER_W-1:0] random_lower;
  } uuid_req_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } uuid_char_t;

  logic clk = 1'b0;
  logic rst_n;

  uuid7_in_if  req_if ();
  uuid7_out_if chr_if ();

  monotonic_uuidv7_generator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_chr (chr_if)
  );

  // Requests waiting to be driven, and characters still owed by the block
  uuid_req_t  pending_reqs[$];
  uuid_char_t owed_chars[$];
  int         n_queued = 0;
  int         n_taken  = 0;
  int         n_fail   = 0;
  int         tx_idle_pct = 12;
  int         rx_idle_pct = 80;

  // Shadow of the generator state
  logic [uuid7_pkg::TIME_W-1:0]   last_ms;
  logic [uuid7_pkg::RUPPER_W-1:0] tail_hi;
  logic [uuid7_pkg::RLOWER_W-1:0] tail_lo;
  logic                           seeded;
  string                          hex_digits = "0123456789abcdef";

  // Base time that random requests wander around
  logic [uuid7_pkg::TIME_W-1:0]   gen_base;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow state by one request and queue its 36 characters
  function automatic void issue_uuid(input uuid_req_t r);
    logic [uuid7_pkg::TIME_W-1:0] use_ms;
    logic [uuid7_pkg::CTR_W:0]    ctr;
    logic                         reseed_now;
    uuid7_pkg::uuid_t             id;
    logic [3:0]                   nib;
    use_ms = (r.now_ms > last_ms) ? r.now_ms : last_ms;
    reseed_now = 1'b1;
    if (seeded && use_ms == last_ms) begin
      // 74 counter bits sit around the version and variant marks
      ctr = {1'b0, tail_hi[11:0], tail_lo[61:0]} + 1'b1;
      reseed_now = ctr[uuid7_pkg::CTR_W];
      if (ctr[uuid7_pkg::CTR_W]) begin
        use_ms = last_ms + 1'b1;
      end else begin
        tail_hi = {uuid7_pkg::VERSION_7, ctr[73:62]};
        tail_lo = {uuid7_pkg::VARIANT_10, ctr[61:0]};
      end
    end
    if (reseed_now) begin
      tail_hi = {uuid7_pkg::VERSION_7, r.random_upper[11:0]};
      tail_lo = {uuid7_pkg::VARIANT_10, r.random_lower[61:0]};
      last_ms = use_ms;
      seeded  = 1'b1;
    end
    id = {use_ms, tail_hi, tail_lo};
    for (int i = 0; i < 32; i++) begin
      if (i == 8 || i == 12 || i == 16 || i == 20) begin
        owed_chars.push_back('{text_char: uuid7_pkg::CHAR_DASH, last_char: 1'b0});
      end
      nib = id[uuid7_pkg::ID_W - 1 - 4 * i -: 4];
      owed_chars.push_back('{text_char: hex_digits[nib], last_char: (i == 31)});
    end
  endfunction

  task automatic queue_req(input logic [47:0] t, input logic [15:0] ru,
                           input logic [63:0] rl);
    pending_reqs.push_back('{now_ms: t, random_upper: ru, random_lower: rl});
    n_queued++;
  endtask

  task automatic queue_random_req();
    logic [47:0] t;
    logic [15:0] ru;
    logic [63:0] rl;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      t = gen_base;
    end else if (sel < 55) begin
      t = gen_base - 48'($urandom_range(1000, 1));
    end else if (sel < 85) begin
      gen_base = gen_base + 48'($urandom_range(3, 1));
      t = gen_base;
    end else if (sel < 93) begin
      t = 48'({$urandom, $urandom} % (64'(gen_base) + 64'd1));
    end else begin
      gen_base = gen_base + 48'($urandom);
      t = gen_base;
    end
    ru = 16'($urandom);
    rl = {$urandom, $urandom};
    // Seed some tails near a counter rollover
    sel = $urandom_range(99);
    if (sel < 12) begin
      ru[11:0] = '1;
      rl[61:0] = '1;
    end else if (sel < 22) begin
      rl[55:0] = '1;
    end
    queue_req(t, ru, rl);
  endtask

  // Hold until every request is taken and every character has come back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || n_taken != n_queued || owed_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Request driver
  always @(posedge clk) begin : drive_req
    uuid_req_t nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_if.valid        <= 1'b1;
        req_if.now_ms       <= nxt.now_ms;
        req_if.random_upper <= nxt.random_upper;
        req_if.random_lower <= nxt.random_lower;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    chr_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Predict on every request transfer
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      issue_uuid('{now_ms: req_if.now_ms, random_upper: req_if.random_upper,
                   random_lower: req_if.random_lower});
      n_taken++;
    end
  end

  // Check every character transfer against the oldest owed character
  always @(posedge clk) begin : check_chr
    uuid_char_t exp_c;
    if (rst_n && chr_if.valid && chr_if.ready) begin
      if (owed_chars.size() == 0) begin
        $error("unexpected character transfer: text_char 0x%02h last_char %0b",
               chr_if.text_char, chr_if.last_char);
        n_fail++;
      end else begin
        exp_c = owed_chars.pop_front();
        if (chr_if.text_char !== exp_c.text_char) begin
          $error("text_char mismatch: expected 0x%02h, got 0x%02h",
                 exp_c.text_char, chr_if.text_char);
          n_fail++;
        end
        if (chr_if.last_char !== exp_c.last_char) begin
          $error("last_char mismatch: expected %0b, got %0b",
                 exp_c.last_char, chr_if.last_char);
          n_fail++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    last_ms = '0;
    tail_hi = '0;
    tail_lo = '0;
    seeded  = 1'b0;
    rst_n   = 1'b0;
    req_if.valid        = 1'b0;
    req_if.now_ms       = '0;
    req_if.random_upper = '0;
    req_if.random_lower = '0;
    chr_if.ready        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First request after reset reseeds, then the same time bumps the counter
    queue_req(48'h0, 16'h0, 64'h0);
    queue_req(48'h0, 16'hFFFF, '1);
    // Reseed with a full counter, then go backwards: counter rolls over
    queue_req(48'h0000_0000_1000, 16'hFFFF, '1);
    queue_req(48'h0000_0000_0FFB, 16'h1234, 64'h0123_4567_89AB_CDEF);
    queue_req(48'h0000_0000_1001, 16'h0, 64'h0);
    // Carry out of the low 56 bits into the 6 middle bits
    queue_req(48'h0123_4567_89AB, 16'h0FFF, 64'h00FF_FFFF_FFFF_FFFF);
    queue_req(48'h0123_4567_89AB, 16'h0, 64'h0);
    // Carry into the top counter nibble
    queue_req(48'h8000_0000_0000, 16'h0AFF, 64'h3FFF_FFFF_FFFF_FFFF);
    queue_req(48'h8000_0000_0000, 16'h0, 64'h0);
    // Full counter at the maximum time: time wraps to zero
    queue_req(48'hFFFF_FFFF_FFFF, 16'hFFFF, '1);
    queue_req(48'hFFFF_FFFF_FFFF, 16'h0, 64'h0);
    queue_req(48'h0000_0000_0005, 16'h5A5A, 64'hA5A5_5A5A_A5A5_5A5A);
    queue_req(48'h0000_0000_0003, 16'hFFFF, '1);
    // Alternating bit patterns, second one backwards
    queue_req(48'hAAAA_AAAA_AAAA, 16'h5555, 64'h5555_5555_5555_5555);
    queue_req(48'h5555_5555_5555, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);

    // Pause the sender until every owed character has come
    wait_drained();
    gen_base = 48'hAAAA_AAAA_AAAA;

    for (int i = 0; i < 150; i++) queue_random_req();
    wait_drained();
    tx_idle_pct = 80;
    rx_idle_pct = 12;
    for (int i = 0; i < 150; i++) queue_random_req();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 150; i++) queue_random_req();
    wait_drained();

    // Let any stray character show up before the verdict
    repeat (50) @(negedge clk);
    if (n_fail == 0) begin
      $display("PASS monotonic_uuidv7_generator_unit");
    end else begin
      $display("FAIL monotonic_uuidv7_generator_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("FAIL monotonic_uuidv7_generator_unit");
    $finish;
  end

endmodule
